// File: hw/rtl/uta_pkg.sv
// Package for the unsigned-to-ASCII radix converter.
// Holds the format codes, digit and character types and the digit-to-ASCII mapping.
// No dependencies.
package uta_pkg;

    // Output format selected by the command field of an input transaction.
    typedef enum logic [1:0] {
        FMT_DEC    = 2'd0,
        FMT_OCT    = 2'd1,
        FMT_HEX_LO = 2'd2,
        FMT_HEX_UP = 2'd3
    } t_fmt;

    localparam int CMD_W  = 2;
    localparam int CHAR_W = 7;

    typedef logic [3:0]        t_digit;
    typedef logic [CHAR_W-1:0] t_char;

    localparam t_digit DIGIT_TEN    = 4'd10;
    localparam t_char  ASCII_ZERO   = 7'd48;
    localparam t_char  ASCII_LO_OFS = 7'd87;
    localparam t_char  ASCII_UP_OFS = 7'd55;

    // Map one digit value to its ASCII code in the given format.
    function automatic t_char f_to_ascii(input t_digit d, input t_fmt fmt);
        t_char ext;
        ext = {3'b000, d};
        if (d < DIGIT_TEN) begin
            return ext + ASCII_ZERO;
        end else if (fmt == FMT_HEX_UP) begin
            return ext + ASCII_UP_OFS;
        end else begin
            return ext + ASCII_LO_OFS;
        end
    endfunction

endpackage

// File: hw/rtl/uta_if.sv
// Handshake interfaces for the unsigned-to-ASCII radix converter.
// uta_in_if carries a format code and a value; uta_out_if carries one character.
// Depends on uta_pkg.
interface uta_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                     valid;
    logic                     ready;
    logic [uta_pkg::CMD_W-1:0] cmd;
    logic [VALUE_WIDTH-1:0]   value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface uta_out_if;
    logic                 valid;
    logic                 ready;
    uta_pkg::t_char       digit_char;
    logic                 last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// File: hw/rtl/unsigned_to_ascii_radix.sv
// Unsigned-to-ASCII radix converter: decimal, octal, lowercase and uppercase hex.
// Pipeline: input register, one double-dabble stage per 8 value bits, a digit-select
// stage and the character serializer.
// Output: one character per cycle while the output is ready; a number gives one
// character per digit (1 to 11 at 32 bits), all sent by the serializer that drives the
// single output channel.
// Reset (synchronous, active low) clears all valid bits; no other state is kept.
module unsigned_to_ascii_radix #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    uta_in_if.sink           i_in,
    uta_out_if.source        o_out
);
    import uta_pkg::*;

    localparam int NSTG       = (VALUE_WIDTH + 7) / 8;
    localparam int PADW       = NSTG * 8;
    localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
    localparam int NDIG       = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int EXT_W      = 4 * NDIG;
    localparam int IDX_W      = $clog2(NDIG);

    // Eight steps of shift-and-add-3 binary to BCD conversion.
    function automatic logic [BCD_W-1:0] f_dabble(input logic [BCD_W-1:0] bcd,
                                                   input logic [7:0] bits);
        logic [BCD_W-1:0] acc;
        acc = bcd;
        for (int b = 7; b >= 0; b--) begin
            for (int d = 0; d < DEC_DIGITS; d++) begin
                if (acc[4*d +: 4] >= 4'd5) begin
                    acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits[b]};
        end
        return acc;
    endfunction

    // Front pipeline: stage 0 is the input register, stages 1..NSTG convert to BCD.
    logic             r_v   [0:NSTG];
    t_fmt             r_cmd [0:NSTG];
    logic [PADW-1:0]  r_val [0:NSTG];
    logic [BCD_W-1:0] r_bcd [1:NSTG];
    logic             w_rdy [0:NSTG];

    // Digit-select stage.
    logic             r_f_valid;
    t_fmt             r_f_cmd;
    t_digit           r_f_dig [NDIG];
    logic [IDX_W-1:0] r_f_top;
    t_digit           n_f_dig [NDIG];
    logic [IDX_W-1:0] n_f_top;
    logic             w_f_rdy;

    // Serializer, which is also the output register.
    logic             r_s_valid;
    t_fmt             r_s_cmd;
    t_digit           r_s_dig [NDIG];
    logic [IDX_W-1:0] r_s_idx;
    logic             w_s_load;

    // Backpressure chain: a stage may load when it is empty or its content moves on.
    assign w_s_load = !r_s_valid || (o_out.ready && (r_s_idx == '0));
    assign w_f_rdy  = !r_f_valid || w_s_load;

    always_comb begin
        w_rdy[NSTG] = !r_v[NSTG] || w_f_rdy;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign i_in.ready = w_rdy[0];

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_v[0] <= i_in.valid;
        end
        if (w_rdy[0]) begin
            r_cmd[0] <= t_fmt'(i_in.cmd);
            r_val[0] <= PADW'(i_in.value[VALUE_WIDTH-1:0]);
        end
    end

    // Double-dabble stages, each consuming the next eight value bits from the top.
    for (genvar j = 1; j <= NSTG; j++) begin : g_dabble
        logic [BCD_W-1:0] w_prev;
        if (j == 1) begin : g_first
            assign w_prev = '0;
        end else begin : g_rest
            assign w_prev = r_bcd[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (w_rdy[j]) begin
                r_v[j] <= r_v[j-1];
            end
            if (w_rdy[j]) begin
                r_cmd[j] <= r_cmd[j-1];
                r_val[j] <= r_val[j-1];
                r_bcd[j] <= f_dabble(w_prev, r_val[j-1][PADW-1-8*(j-1) -: 8]);
            end
        end
    end

    // Pick the digit vector for the format and locate the top nonzero digit.
    always_comb begin
        logic [EXT_W-1:0] ext;
        logic [EXT_W-1:0] bcd_ext;
        ext     = EXT_W'(r_val[NSTG][VALUE_WIDTH-1:0]);
        bcd_ext = EXT_W'(r_bcd[NSTG]);
        n_f_top = '0;
        for (int i = 0; i < NDIG; i++) begin
            unique case (r_cmd[NSTG])
                FMT_DEC:    n_f_dig[i] = bcd_ext[4*i +: 4];
                FMT_OCT:    n_f_dig[i] = {1'b0, ext[3*i +: 3]};
                FMT_HEX_LO,
                FMT_HEX_UP: n_f_dig[i] = ext[4*i +: 4];
                default:    n_f_dig[i] = '0;
            endcase
            if (n_f_dig[i] != '0) begin
                n_f_top = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_f_rdy) begin
            r_f_valid <= r_v[NSTG];
        end
        if (w_f_rdy) begin
            r_f_cmd <= r_cmd[NSTG];
            r_f_dig <= n_f_dig;
            r_f_top <= n_f_top;
        end
    end

    // Serializer: emits from the top digit down and loads the next number after the last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (w_s_load) begin
            r_s_valid <= r_f_valid;
        end
        if (w_s_load) begin
            r_s_cmd <= r_f_cmd;
            r_s_dig <= r_f_dig;
            r_s_idx <= r_f_top;
        end else if (o_out.ready) begin
            r_s_idx <= r_s_idx - IDX_W'(1);
        end
    end

    // Output transaction.
    assign o_out.valid      = r_s_valid;
    assign o_out.digit_char = f_to_ascii(r_s_dig[r_s_idx], r_s_cmd);
    assign o_out.last       = (r_s_idx == '0);

endmodule

// File: bench/unsigned_to_ascii_radix_tb.sv
// Testbench for the unsigned-to-ASCII radix converter.
// It predicts the digit characters of each accepted number and checks every output character.
// Depends on uta_pkg, uta_if.sv and unsigned_to_ascii_radix.sv.
module unsigned_to_ascii_radix_tb;
    import uta_pkg::*;

    localparam int VW           = 32;
    localparam int MAX_DIGITS   = 11;
    localparam int IDLE_PERCENT = 14;
    localparam int STALL_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 16;

    // One expected output character.
    typedef struct packed {
        t_char digit_char;
        logic  last;
    } t_exp_char;

    logic i_clk;
    logic i_rst_n;

    uta_in_if #(.VALUE_WIDTH(VW)) in_ch ();
    uta_out_if                    out_ch ();

    unsigned_to_ascii_radix #(.VALUE_WIDTH(VW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_exp_char expected_chars[$];
    int        mismatches   = 0;
    int        stall_cycles = 0;
    bit        steady_phase = 1'b0;

    // Clock generation.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Queue the digit characters of one number, most significant first.
    task automatic push_digit_chars(input t_fmt fmt, input logic [VW-1:0] value);
        logic [VW-1:0] rest;
        int unsigned   radix;
        int unsigned   digit_vals[MAX_DIGITS];
        int            n;
        t_exp_char     item;
        int unsigned   d;
        case (fmt)
            FMT_DEC: radix = 10;
            FMT_OCT: radix = 8;
            default: radix = 16;
        endcase
        rest = value;
        n    = 0;
        do begin
            digit_vals[n] = rest % radix;
            rest          = rest / radix;
            n++;
        end while (rest != 0);
        for (int k = n - 1; k >= 0; k--) begin
            d = digit_vals[k];
            if (d < 10) begin
                item.digit_char = ASCII_ZERO + t_char'(d);
            end else if (fmt == FMT_HEX_UP) begin
                item.digit_char = ASCII_UP_OFS + t_char'(d);
            end else begin
                item.digit_char = ASCII_LO_OFS + t_char'(d);
            end
            item.last = (k == 0);
            expected_chars.push_back(item);
        end
    endtask

    // Offer one number, with random idle cycles ahead of it outside steady phases.
    task automatic send_number(input t_fmt fmt, input logic [VW-1:0] value);
        while (!steady_phase && $urandom_range(99) < IDLE_PERCENT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= fmt;
        in_ch.value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        push_digit_chars(fmt, value);
    endtask

    // Random number whose bit length is spread evenly, so short numbers are common.
    function automatic logic [VW-1:0] random_number();
        logic [VW-1:0] v;
        int unsigned   len;
        v   = $urandom;
        len = $urandom_range(VW, 1);
        if (len < VW) begin
            v = v & ((32'd1 << len) - 1);
        end
        if ($urandom_range(19) == 0) begin
            v = '0;
        end
        return v;
    endfunction

    // Zero gives a single '0' in every format.
    task automatic test_zero_value();
        for (int f = 0; f < 4; f++) begin
            send_number(t_fmt'(f), '0);
        end
    endtask

    // All ones gives the longest run in each format.
    task automatic test_max_value();
        for (int f = 0; f < 4; f++) begin
            send_number(t_fmt'(f), '1);
        end
    endtask

    // Values on either side of a digit-count step, and every hex letter in both cases.
    task automatic test_digit_boundaries();
        send_number(FMT_DEC, 32'd9);
        send_number(FMT_DEC, 32'd10);
        send_number(FMT_OCT, 32'd7);
        send_number(FMT_OCT, 32'd8);
        send_number(FMT_OCT, 32'h8000_0000);
        send_number(FMT_HEX_LO, 32'hF);
        send_number(FMT_HEX_LO, 32'h10);
        send_number(FMT_HEX_LO, 32'hFEDC_BA98);
        send_number(FMT_HEX_UP, 32'hF);
        send_number(FMT_HEX_UP, 32'hFEDC_BA98);
        send_number(FMT_DEC, 32'd1);
    endtask

    // Random numbers and formats with idle cycles on both sides.
    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++) begin
            send_number(t_fmt'($urandom_range(3)), random_number());
        end
    endtask

    // Random numbers with neither side ever idle.
    task automatic test_back_to_back(input int count);
        steady_phase = 1'b1;
        for (int i = 0; i < count; i++) begin
            send_number(t_fmt'($urandom_range(3)), random_number());
        end
        steady_phase = 1'b0;
    endtask

    // Wait for every expected character, then keep watching for stray characters.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Output ready with random stalls outside steady phases.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= steady_phase || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Compare each output transaction with the oldest expected character.
    always @(posedge i_clk) begin
        t_exp_char exp_item;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_chars.size() == 0) begin
                $error("digit_char: unexpected character, actual %0d", out_ch.digit_char);
                mismatches++;
            end else begin
                exp_item = expected_chars.pop_front();
                if (out_ch.digit_char !== exp_item.digit_char) begin
                    $error("digit_char: expected %0d, actual %0d",
                           exp_item.digit_char, out_ch.digit_char);
                    mismatches++;
                end
                if (out_ch.last !== exp_item.last) begin
                    $error("last: expected %0d, actual %0d", exp_item.last, out_ch.last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.cmd   <= FMT_DEC;
        in_ch.value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_value();
        test_max_value();
        test_digit_boundaries();
        test_random_traffic(74);
        test_back_to_back(64);
        test_random_traffic(73);
        wait_drained();

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/uta_pkg.sv
hw/rtl/uta_if.sv
hw/rtl/unsigned_to_ascii_radix.sv
bench/unsigned_to_ascii_radix_tb.sv
